### src/sd_card_init_sequencer_core_defines.svh
// Assertion macros shared by the SD card initialization sequencer RTL.
`ifndef SD_CARD_INIT_SEQUENCER_CORE_DEFINES_SVH
`define SD_CARD_INIT_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SDI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SDI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sdinit_pkg.sv
// Types and constants of the SD card initialization sequencer.
package sdinit_pkg;

    // Sequence steps, one-hot.
    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_CMD0     = 14'b00000000000010,
        ST_CMD8     = 14'b00000000000100,
        ST_CMD55_A  = 14'b00000000001000,
        ST_ACMD41_A = 14'b00000000010000,
        ST_CMD55_P  = 14'b00000000100000,
        ST_ACMD41_P = 14'b00000001000000,
        ST_CMD2     = 14'b00000010000000,
        ST_CMD3     = 14'b00000100000000,
        ST_CMD9     = 14'b00001000000000,
        ST_CMD7     = 14'b00010000000000,
        ST_CMD16    = 14'b00100000000000,
        ST_CMD55_B  = 14'b01000000000000,
        ST_ACMD6    = 14'b10000000000000
    } step_t;

    // Event opcodes.
    localparam logic OP_START    = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // Command outcomes.
    localparam logic [1:0] OUT_OK      = 2'd0;
    localparam logic [1:0] OUT_NO_RESP = 2'd1;
    localparam logic [1:0] OUT_ERROR   = 2'd2;
    localparam logic [1:0] OUT_REMOVED = 2'd3;

    // Final status codes.
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NOCARD = 2'd1;
    localparam logic [1:0] STATUS_NOINIT = 2'd2;

    // SD command numbers.
    localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
    localparam logic [5:0] CMD_ALL_CID    = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA   = 6'd3;
    localparam logic [5:0] CMD_BUS_WIDTH  = 6'd6;
    localparam logic [5:0] CMD_SELECT     = 6'd7;
    localparam logic [5:0] CMD_IF_COND    = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD   = 6'd9;
    localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
    localparam logic [5:0] CMD_OP_COND    = 6'd41;
    localparam logic [5:0] CMD_APP        = 6'd55;

    // Argument and response constants.
    localparam logic [31:0] CHECK_PATTERN = 32'h0000_01AA;
    localparam logic [31:0] VOLT_WINDOW   = 32'h0030_0000;
    localparam logic [31:0] HCS_BIT       = 32'h4000_0000;
    localparam logic [31:0] READY_BIT     = 32'h8000_0000;
    localparam logic [31:0] WIDTH4_ARG    = 32'h0000_0002;

    // Configuration register word indexes.
    localparam logic REG_POLL_LIMIT = 1'b0;
    localparam logic REG_BLOCK_LEN  = 1'b1;

    // One input event.
    typedef struct packed {
        logic        opcode;
        logic        card_present;
        logic [1:0]  command_outcome;
        logic [31:0] response_word0;
        logic [31:0] response_word1;
        logic [31:0] response_word2;
        logic [31:0] response_word3;
    } event_t;

    // Sequencer state carried from event to event.
    typedef struct packed {
        step_t       step;
        logic [15:0] poll_count;
        logic        capacity_flag;
        logic        version_flag;
        logic [15:0] address;
        logic [32:0] blocks;
    } card_state_t;

    // One result word.
    typedef struct packed {
        logic        issue_command;
        logic [5:0]  command_index;
        logic [31:0] command_argument;
        logic        init_done;
        logic [1:0]  init_status;
        logic        high_capacity;
        logic        csd_version_two;
        logic [15:0] relative_address;
        logic [32:0] block_count;
    } result_t;

endpackage

### src/sd_card_init_sequencer_core.sv
// Top level of the SD card initialization sequencer: channels, registers, state.
//
//  Channel    | Direction | Signals                                  | Moves
//  -----------+-----------+------------------------------------------+-----------------------
//  s_axis     | in        | s_tvalid s_tready s_tdata s_tuser        | one event word
//  m_axis     | out       | m_tvalid m_tready m_tdata                | one result word
//  apb        | in        | psel penable pwrite paddr pwdata prdata  | register access
//
// Each event word is captured in an input register; once the result register is
// free or is being drained, the step logic decodes it against the stored sequence
// state and loads the result register, so one word is accepted every cycle while
// the result side keeps up. The state update and the result load happen at the
// same edge, which is what lets back-to-back events see fresh state.
// A stalled result register holds the input register, and s_tready then falls.
// rst_n clears the handshake and sequence state asynchronously; the configuration
// registers return to a retry limit of 1000 and a block length of 512.
`include "sd_card_init_sequencer_core_defines.svh"

module sd_card_init_sequencer_core
    import sdinit_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    // Bits from 0 up: card_present, command_outcome[1:0], response_word0..3, zero pad.
    input  logic [135:0] s_tdata,
    // Bit 0: opcode.
    input  logic         s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // Bits from 0 up: issue_command, command_index[5:0], command_argument[31:0],
    // init_done, init_status[1:0], high_capacity, csd_version_two,
    // relative_address[15:0], block_count[32:0], zero pad.
    output logic [95:0]  m_tdata,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // Configuration registers.
    logic [15:0] poll_limit_reg;
    logic [11:0] block_len_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg <= 16'd1000;
            block_len_reg  <= 12'd512;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_POLL_LIMIT: poll_limit_reg <= pwdata[15:0];
                REG_BLOCK_LEN:  block_len_reg  <= pwdata[11:0];
                default:        poll_limit_reg <= poll_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_POLL_LIMIT: prdata = {16'd0, poll_limit_reg};
            REG_BLOCK_LEN:  prdata = {20'd0, block_len_reg};
            default:        prdata = '0;
        endcase
    end

    // Input register and result register with their valid flags.
    logic        in_valid_reg;
    event_t      in_event_reg;
    logic        out_valid_reg;
    result_t     out_result_reg;
    card_state_t state_reg;

    card_state_t state_next;
    logic        has_result;
    result_t     result_next;
    logic        advance;

    // The held event moves on once the result register is free or is being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    sdinit_step u_step (
        .cur              (state_reg),
        .evt              (in_event_reg),
        .poll_retry_limit (poll_limit_reg),
        .block_length     (block_len_reg),
        .nxt              (state_next),
        .has_result       (has_result),
        .res              (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_event_reg.opcode          <= s_tuser;
            in_event_reg.card_present    <= s_tdata[0];
            in_event_reg.command_outcome <= s_tdata[2:1];
            in_event_reg.response_word0  <= s_tdata[34:3];
            in_event_reg.response_word1  <= s_tdata[66:35];
            in_event_reg.response_word2  <= s_tdata[98:67];
            in_event_reg.response_word3  <= s_tdata[130:99];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.step          <= ST_IDLE;
            state_reg.poll_count    <= '0;
            state_reg.capacity_flag <= 1'b0;
            state_reg.version_flag  <= 1'b0;
            state_reg.address       <= '0;
            state_reg.blocks        <= '0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= has_result;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
            out_result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0,
                       out_result_reg.block_count,
                       out_result_reg.relative_address,
                       out_result_reg.csd_version_two,
                       out_result_reg.high_capacity,
                       out_result_reg.init_status,
                       out_result_reg.init_done,
                       out_result_reg.command_argument,
                       out_result_reg.command_index,
                       out_result_reg.issue_command};

    // A result either issues a command or ends the run, never both or neither.
    `SDI_ASSERT_NOW(a_issue_xor_done, out_valid_reg,
        out_result_reg.issue_command != out_result_reg.init_done,
        "result both issues a command and ends the run")
    // A version 1 CSD never yields a capacity that needs the top bit.
    `SDI_ASSERT_NOW(a_v1_capacity_range, out_valid_reg && !out_result_reg.csd_version_two,
        out_result_reg.block_count[32] == 1'b0,
        "version 1 capacity overflows 32 bits")
    // A full input register behind a stalled result must not take another word.
    `SDI_ASSERT_NOW(a_stall_blocks_input, in_valid_reg && out_valid_reg && !m_tready,
        !s_tready, "input accepted while both registers are blocked")
    // An ended run leaves the sequencer idle.
    `SDI_ASSERT_NEXT(a_done_goes_idle, advance && has_result && result_next.init_done,
        state_reg.step == ST_IDLE, "sequence not idle after the run ended")

endmodule

### src/sdinit_step.sv
// Next-state and result logic of the SD card initialization sequencer.
module sdinit_step
    import sdinit_pkg::*;
(
    input  card_state_t cur,
    input  event_t      evt,
    input  logic [15:0] poll_retry_limit,
    input  logic [11:0] block_length,
    output card_state_t nxt,
    output logic        has_result,
    output result_t     res
);

    // Capacity in 512-byte blocks from the CSD words.
    function automatic logic [32:0] csd_blocks(input logic [31:0] w1, input logic [31:0] w2,
                                               input logic v2);
        logic [3:0]  bl;
        logic [12:0] cs1;
        logic [3:0]  sh;
        logic [22:0] cs2;
        begin
            if (!v2)
            begin
                bl  = (w2[11:8] < 4'd9) ? 4'd9 : w2[11:8];
                cs1 = {1'b0, w2[1:0], w1[31:22]} + 13'd1;
                sh  = {1'b0, w1[9:7]} + 4'd2 + (bl - 4'd9);
                csd_blocks = {20'd0, cs1} << sh;
            end
            else
            begin
                cs2 = {1'b0, w1[29:8]} + 23'd1;
                csd_blocks = {cs2, 10'd0};
            end
        end
    endfunction

    logic        ok;
    logic [31:0] rca_arg;
    logic        poll_over;

    assign ok        = (evt.command_outcome == OUT_OK);
    assign rca_arg   = {cur.address, 16'd0};
    assign poll_over = (cur.poll_count >= poll_retry_limit);

    always_comb
    begin
        nxt        = cur;
        has_result = 1'b1;
        res        = '0;

        if (evt.opcode == OP_START)
        begin
            nxt.capacity_flag = 1'b0;
            nxt.version_flag  = 1'b0;
            nxt.address       = '0;
            nxt.blocks        = '0;
            nxt.poll_count    = '0;
            if (!evt.card_present)
            begin
                nxt.step        = ST_IDLE;
                res.init_done   = 1'b1;
                res.init_status = STATUS_NOCARD;
            end
            else
            begin
                nxt.step          = ST_CMD0;
                res.issue_command = 1'b1;
                res.command_index = CMD_GO_IDLE;
            end
        end
        else
        begin
            // Every step issues a command unless the run ends below, on a failure or after ACMD6.
            res.issue_command = 1'b1;
            case (cur.step)
                ST_CMD0:
                begin
                    nxt.step             = ST_CMD8;
                    res.command_index    = CMD_IF_COND;
                    res.command_argument = CHECK_PATTERN;
                    if (!ok)
                        res.issue_command = 1'b0;
                end
                ST_CMD8:
                begin
                    nxt.step          = ST_CMD55_A;
                    res.command_index = CMD_APP;
                    if (ok)
                    begin
                        if (evt.response_word0 != CHECK_PATTERN)
                            res.issue_command = 1'b0;
                        else
                            nxt.capacity_flag = 1'b1;
                    end
                    else if (evt.command_outcome != OUT_NO_RESP)
                        res.issue_command = 1'b0;
                end
                ST_CMD55_A:
                begin
                    nxt.step          = ST_ACMD41_A;
                    res.command_index = CMD_OP_COND;
                end
                ST_ACMD41_A:
                begin
                    if (!ok)
                        res.issue_command = 1'b0;
                    else if ((evt.response_word0 & VOLT_WINDOW) != '0)
                    begin
                        nxt.poll_count    = '0;
                        nxt.step          = ST_CMD55_P;
                        res.command_index = CMD_APP;
                    end
                    else
                    begin
                        nxt.step          = ST_CMD2;
                        res.command_index = CMD_ALL_CID;
                    end
                end
                ST_CMD55_P:
                begin
                    nxt.poll_count       = cur.poll_count + 16'd1;
                    nxt.step             = ST_ACMD41_P;
                    res.command_index    = CMD_OP_COND;
                    res.command_argument = VOLT_WINDOW | (cur.capacity_flag ? HCS_BIT : '0);
                end
                ST_ACMD41_P:
                begin
                    if (!ok)
                        res.issue_command = 1'b0;
                    else if (((evt.response_word0 & READY_BIT) == '0) && !poll_over)
                    begin
                        nxt.step          = ST_CMD55_P;
                        res.command_index = CMD_APP;
                    end
                    else
                    begin
                        if (poll_over || ((evt.response_word0 & HCS_BIT) == '0))
                            nxt.capacity_flag = 1'b0;
                        nxt.step          = ST_CMD2;
                        res.command_index = CMD_ALL_CID;
                    end
                end
                ST_CMD2:
                begin
                    nxt.step          = ST_CMD3;
                    res.command_index = CMD_SEND_RCA;
                    if (!ok)
                        res.issue_command = 1'b0;
                end
                ST_CMD3:
                begin
                    if (!ok)
                        res.issue_command = 1'b0;
                    else
                    begin
                        nxt.address          = evt.response_word0[31:16];
                        nxt.step             = ST_CMD9;
                        res.command_index    = CMD_SEND_CSD;
                        res.command_argument = {evt.response_word0[31:16], 16'd0};
                    end
                end
                ST_CMD9:
                begin
                    if (!ok)
                        res.issue_command = 1'b0;
                    else
                    begin
                        nxt.version_flag     = (evt.response_word3[23:22] != 2'b00);
                        nxt.blocks           = csd_blocks(evt.response_word1,
                                                          evt.response_word2,
                                                          nxt.version_flag);
                        nxt.step             = ST_CMD7;
                        res.command_index    = CMD_SELECT;
                        res.command_argument = rca_arg;
                    end
                end
                ST_CMD7:
                begin
                    nxt.step             = ST_CMD16;
                    res.command_index    = CMD_BLOCKLEN;
                    res.command_argument = {20'd0, block_length};
                    if (!ok)
                        res.issue_command = 1'b0;
                end
                ST_CMD16:
                begin
                    nxt.step             = ST_CMD55_B;
                    res.command_index    = CMD_APP;
                    res.command_argument = rca_arg;
                    if (!ok)
                        res.issue_command = 1'b0;
                end
                ST_CMD55_B:
                begin
                    nxt.step             = ST_ACMD6;
                    res.command_index    = CMD_BUS_WIDTH;
                    res.command_argument = WIDTH4_ARG;
                end
                ST_ACMD6:
                begin
                    res.issue_command = 1'b0;
                end
                default:
                begin
                    // A completion with no run in progress is dropped.
                    has_result        = 1'b0;
                    res.issue_command = 1'b0;
                end
            endcase

            // The run ends here: success after ACMD6, otherwise a failure.
            if (has_result && !res.issue_command)
            begin
                nxt.step             = ST_IDLE;
                nxt.poll_count       = cur.poll_count;
                nxt.capacity_flag    = cur.capacity_flag;
                nxt.version_flag     = cur.version_flag;
                nxt.address          = cur.address;
                nxt.blocks           = cur.blocks;
                res.command_index    = '0;
                res.command_argument = '0;
                res.init_done        = 1'b1;
                res.init_status      = (cur.step == ST_ACMD6 && ok) ? STATUS_OK
                                                                    : STATUS_NOINIT;
            end
        end

        res.high_capacity    = nxt.capacity_flag;
        res.csd_version_two  = nxt.version_flag;
        res.relative_address = nxt.address;
        res.block_count      = nxt.blocks;
    end

endmodule
